FILE: rtl/stst_pkg.sv
// ----------------------------------------------------------------------------
// stst_pkg
// shared types and constants of the sender tagged message slot table
// ----------------------------------------------------------------------------
`default_nettype none

package stst_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SEQ_W  = 31;
  localparam int MAC_W  = 48;
  localparam int LEN_W  = 8;
  localparam int DROP_W = 32;

  localparam logic [SEQ_W-1:0] SEQ_TOP     = 31'h7fffffff;
  localparam logic [LEN_W-1:0] MAX_PAY_RST = 8'd250;

  typedef enum logic [1:0] {
    ACT_RECV  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_COUNT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic              en_seq;
    logic              en_data;
    logic [SLOT_W-1:0] idx;
    logic [SEQ_W-1:0]  seq;
    logic [MAC_W-1:0]  sender;
    logic [LEN_W-1:0]  len;
  } stst_wr_t;

endpackage

`default_nettype wire

FILE: rtl/sender_tagged_message_slot_table_top.sv
// ----------------------------------------------------------------------------
// sender_tagged_message_slot_table_top
// slot table for received messages tagged by sender address
// ----------------------------------------------------------------------------
// Each transfer is one action: receive stores a sender and a clipped length in
// the highest-numbered free slot, pop frees the oldest live entry (optionally
// from one sender only) and count returns the number of matching live entries.
// The slots are visited one per cycle through a single shared comparator; an
// item is accepted, then scanned slot by slot, then finished, and only then is
// the next item accepted. The result sits in an output register, so the next
// item can be accepted while it waits; the finish step stalls only while an
// earlier result is untaken.
// The slot index addresses an external payload buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sender_tagged_message_slot_table_top (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_wr_en,
  input  wire  [stst_pkg::LEN_W-1:0]    cfg_wr_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [1:0]                    in_action,
  input  wire  [stst_pkg::MAC_W-1:0]    in_peer_mac,
  input  wire                           in_use_filter,
  input  wire  [stst_pkg::LEN_W-1:0]    in_msg_length,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_ok,
  output logic [2:0]                    out_slot,
  output logic [stst_pkg::MAC_W-1:0]    out_sender,
  output logic [stst_pkg::LEN_W-1:0]    out_stored_length,
  output logic [3:0]                    out_available,
  output logic [stst_pkg::DROP_W-1:0]   out_drops
);
  import stst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   max_pay_r;
  logic [DROP_W-1:0]  drop_r, drop_nxt;

  action_t            act_r, act_nxt;
  logic [MAC_W-1:0]   mac_r, mac_nxt;
  logic               filt_r, filt_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;

  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic [SEQ_W-1:0]   acc_r, acc_nxt;
  logic               found_r, found_nxt;
  logic [SLOT_W-1:0]  pick_r, pick_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MAC_W-1:0]   cap_sender_r, cap_sender_nxt;
  logic [LEN_W-1:0]   cap_len_r, cap_len_nxt;

  logic               ovld_r, ovld_nxt;
  logic               ook_r, ook_nxt;
  logic [2:0]         oslot_r, oslot_nxt;
  logic [MAC_W-1:0]   osender_r, osender_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;
  logic [3:0]         oavail_r, oavail_nxt;
  logic [DROP_W-1:0]  odrops_r, odrops_nxt;

  logic [SEQ_W-1:0]   rd_seq;
  logic [MAC_W-1:0]   rd_sender;
  logic [LEN_W-1:0]   rd_len;
  stst_wr_t           wr;

  logic               is_free, match, lt;
  logic [SEQ_W-1:0]   cmp_a, cmp_b;
  logic               out_free;

  stst_slot_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r),
    .wr        (wr),
    .rd_seq    (rd_seq),
    .rd_sender (rd_sender),
    .rd_len    (rd_len)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !ovld_r || out_ready;

  // shared comparator: operands swap between min search and max search
  assign is_free = (rd_seq == '0);
  assign match   = !is_free && (!filt_r || (rd_sender == mac_r));
  assign cmp_a   = (act_r == ACT_POP) ? rd_seq : acc_r;
  assign cmp_b   = (act_r == ACT_POP) ? acc_r : rd_seq;
  assign lt      = (cmp_a < cmp_b);

  always_comb begin
    state_nxt      = state_r;
    drop_nxt       = drop_r;
    act_nxt        = act_r;
    mac_nxt        = mac_r;
    filt_nxt       = filt_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    acc_nxt        = acc_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    cnt_nxt        = cnt_r;
    cap_sender_nxt = cap_sender_r;
    cap_len_nxt    = cap_len_r;
    ovld_nxt       = ovld_r && !out_ready;
    ook_nxt        = ook_r;
    oslot_nxt      = oslot_r;
    osender_nxt    = osender_r;
    olen_nxt       = olen_r;
    oavail_nxt     = oavail_r;
    odrops_nxt     = odrops_r;
    wr             = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt   = action_t'(in_action);
          mac_nxt   = in_peer_mac;
          filt_nxt  = in_use_filter;
          if (in_msg_length > max_pay_r) begin
            len_nxt = (max_pay_r == '0) ? '0 : max_pay_r - LEN_W'(1);
          end else begin
            len_nxt = in_msg_length;
          end
          idx_nxt   = '0;
          acc_nxt   = '0;
          found_nxt = 1'b0;
          pick_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        case (act_r)
          ACT_RECV: begin
            if (is_free) begin
              found_nxt = 1'b1;
              pick_nxt  = idx_r;
            end
            if (lt) begin
              acc_nxt = rd_seq;
            end
          end
          ACT_POP: begin
            if (match && (!found_r || lt)) begin
              found_nxt      = 1'b1;
              pick_nxt       = idx_r;
              acc_nxt        = rd_seq;
              cap_sender_nxt = rd_sender;
              cap_len_nxt    = rd_len;
            end
          end
          ACT_COUNT: begin
            if (match) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
        if (idx_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ovld_nxt    = 1'b1;
          ook_nxt     = 1'b0;
          oslot_nxt   = '0;
          osender_nxt = '0;
          olen_nxt    = '0;
          oavail_nxt  = '0;
          case (act_r)
            ACT_RECV: begin
              if (found_r) begin
                wr.en_seq  = 1'b1;
                wr.en_data = 1'b1;
                wr.idx     = pick_r;
                wr.seq     = (acc_r == SEQ_TOP) ? SEQ_TOP : acc_r + SEQ_W'(1);
                wr.sender  = mac_r;
                wr.len     = len_r;
                ook_nxt    = 1'b1;
                oslot_nxt  = 3'(pick_r);
                olen_nxt   = len_r;
              end else begin
                drop_nxt = drop_r + DROP_W'(1);
              end
            end
            ACT_POP: begin
              if (found_r) begin
                wr.en_seq   = 1'b1;
                wr.idx      = pick_r;
                ook_nxt     = 1'b1;
                oslot_nxt   = 3'(pick_r);
                osender_nxt = cap_sender_r;
                olen_nxt    = cap_len_r;
              end
            end
            ACT_COUNT: begin
              oavail_nxt = 4'(cnt_r);
            end
            default: begin
            end
          endcase
          odrops_nxt = drop_nxt;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      drop_r    <= '0;
      max_pay_r <= MAX_PAY_RST;
      ovld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
      ovld_r  <= ovld_nxt;
      if (cfg_wr_en) begin
        max_pay_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    mac_r        <= mac_nxt;
    filt_r       <= filt_nxt;
    len_r        <= len_nxt;
    idx_r        <= idx_nxt;
    acc_r        <= acc_nxt;
    found_r      <= found_nxt;
    pick_r       <= pick_nxt;
    cnt_r        <= cnt_nxt;
    cap_sender_r <= cap_sender_nxt;
    cap_len_r    <= cap_len_nxt;
    ook_r        <= ook_nxt;
    oslot_r      <= oslot_nxt;
    osender_r    <= osender_nxt;
    olen_r       <= olen_nxt;
    oavail_r     <= oavail_nxt;
    odrops_r     <= odrops_nxt;
  end

  assign out_valid         = ovld_r;
  assign out_ok            = ook_r;
  assign out_slot          = oslot_r;
  assign out_sender        = osender_r;
  assign out_stored_length = olen_r;
  assign out_available     = oavail_r;
  assign out_drops         = odrops_r;

endmodule

`default_nettype wire

FILE: rtl/stst_slot_store.sv
// ----------------------------------------------------------------------------
// stst_slot_store
// per-slot sequence, sender and length storage with one scan read port
// ----------------------------------------------------------------------------
`default_nettype none

module stst_slot_store (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [stst_pkg::SLOT_W-1:0]   rd_idx,
  input  wire  stst_pkg::stst_wr_t      wr,
  output logic [stst_pkg::SEQ_W-1:0]    rd_seq,
  output logic [stst_pkg::MAC_W-1:0]    rd_sender,
  output logic [stst_pkg::LEN_W-1:0]    rd_len
);
  import stst_pkg::*;

  logic [SEQ_W-1:0] seq_r    [SLOTS];
  logic [MAC_W-1:0] sender_r [SLOTS];
  logic [LEN_W-1:0] len_r    [SLOTS];

  // sequence zero marks a free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        seq_r[i] <= '0;
      end
    end else if (wr.en_seq) begin
      seq_r[wr.idx] <= wr.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en_data) begin
      sender_r[wr.idx] <= wr.sender;
      len_r[wr.idx]    <= wr.len;
    end
  end

  assign rd_seq    = seq_r[rd_idx];
  assign rd_sender = sender_r[rd_idx];
  assign rd_len    = len_r[rd_idx];

endmodule

`default_nettype wire
